@@ hdl/sstf_pkg.sv @@
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants for the shortest-seek-first request scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int MAX_REQUESTS_DEF = 16;

    localparam int TRACK_W = 16;
    localparam int INDEX_W = 4;
    localparam int SUM_W   = 20;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef struct packed {
        logic               op;
        logic [TRACK_W-1:0] track;
    } in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] request_index;
        logic [TRACK_W-1:0] from_track;
        logic [TRACK_W-1:0] to_track;
        logic [TRACK_W-1:0] seek_distance;
        logic [SUM_W-1:0]   total_distance;
        logic               last;
    } out_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic run;
        logic scan_step;
        logic emit;
    } sstf_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic count_zero;
        logic scan_done;
        logic left_one;
        logic best_found;
    } sstf_stat_t;

endpackage

@@ hdl/sstf_dp.sv @@
// ----------------------------------------------------------------------------
// sstf_dp
// Datapath: request track memory, served flags, nearest-request scan and
// the result register.
// ----------------------------------------------------------------------------
module sstf_dp #(
    parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sstf_pkg::sstf_cmd_t  cmd,
    input  sstf_pkg::in_t      in_data,
    output sstf_pkg::sstf_stat_t status,
    output sstf_pkg::out_t     out_data
);
    import sstf_pkg::*;

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [TRACK_W-1:0]      mem [MAX_REQUESTS];

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        left_reg;
    logic [CNT_W-1:0]        addr_reg;
    logic [MAX_REQUESTS-1:0] served_reg;
    logic [TRACK_W-1:0]      head_reg;
    logic [SUM_W-1:0]        sum_reg;

    logic [TRACK_W-1:0]      rd_data_reg;
    logic                    cmp_valid_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;

    logic                    best_found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [TRACK_W-1:0]      best_dist_reg;
    logic [TRACK_W-1:0]      best_track_reg;

    out_t                    out_reg;

    logic                    full;
    logic                    issue;
    logic [TRACK_W-1:0]      cur_dist;
    logic                    take;
    logic [SUM_W:0]          sum_wide;
    logic [SUM_W-1:0]        sum_sat;
    logic [IDX_W+INDEX_W-1:0] idx_wide;

    assign full  = (count_reg == CNT_MAX);
    assign issue = cmd.scan_step && (addr_reg != count_reg);

    assign cur_dist = (rd_data_reg > head_reg) ? (rd_data_reg - head_reg)
                                               : (head_reg - rd_data_reg);

    // strict compare keeps the lowest index on a tie
    assign take = cmd.scan_step && cmp_valid_reg && !served_reg[cmp_idx_reg] &&
                  (!best_found_reg || (cur_dist < best_dist_reg));

    assign sum_wide = {1'b0, sum_reg} + {{(SUM_W+1-TRACK_W){1'b0}}, best_dist_reg};
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign idx_wide = {{INDEX_W{1'b0}}, best_idx_reg};

    // request memory, one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.load && !full) begin
            mem[count_reg[IDX_W-1:0]] <= in_data.track;
        end
        if (issue) begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            left_reg       <= '0;
            addr_reg       <= '0;
            served_reg     <= '0;
            head_reg       <= '0;
            sum_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
        end else begin
            if (cmd.load && !full) begin
                count_reg <= count_reg + CNT_ONE;
            end
            if (cmd.run) begin
                head_reg       <= in_data.track;
                sum_reg        <= '0;
                served_reg     <= '0;
                left_reg       <= count_reg;
                addr_reg       <= '0;
                cmp_valid_reg  <= 1'b0;
                best_found_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                if (issue) begin
                    addr_reg <= addr_reg + CNT_ONE;
                end
                cmp_valid_reg <= issue;
                if (take) begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.emit) begin
                head_reg       <= best_track_reg;
                sum_reg        <= sum_sat;
                left_reg       <= left_reg - CNT_ONE;
                addr_reg       <= '0;
                cmp_valid_reg  <= 1'b0;
                best_found_reg <= 1'b0;
                // end of run drops the stored requests
                if (left_reg == CNT_ONE) begin
                    count_reg  <= '0;
                    served_reg <= '0;
                end else begin
                    served_reg[best_idx_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            cmp_idx_reg <= addr_reg[IDX_W-1:0];
        end
        if (take) begin
            best_idx_reg   <= cmp_idx_reg;
            best_dist_reg  <= cur_dist;
            best_track_reg <= rd_data_reg;
        end
        if (cmd.emit) begin
            out_reg.request_index  <= idx_wide[INDEX_W-1:0];
            out_reg.from_track     <= head_reg;
            out_reg.to_track       <= best_track_reg;
            out_reg.seek_distance  <= best_dist_reg;
            out_reg.total_distance <= sum_sat;
            out_reg.last           <= (left_reg == CNT_ONE);
        end
    end

    assign status.count_zero = (count_reg == '0);
    assign status.scan_done  = (addr_reg == count_reg) && !cmp_valid_reg;
    assign status.left_one   = (left_reg == CNT_ONE);
    assign status.best_found = best_found_reg;

    assign out_data = out_reg;

endmodule

@@ hdl/sstf_ctrl.sv @@
// ----------------------------------------------------------------------------
// sstf_ctrl
// Controller: input handshake, scan sequencing and result valid flag.
// ----------------------------------------------------------------------------
module sstf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_op,
    input  logic                 m_ready,
    input  sstf_pkg::sstf_stat_t status,
    output logic                 s_ready,
    output logic                 m_valid,
    output sstf_pkg::sstf_cmd_t  cmd
);
    import sstf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       accept;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign cmd.load      = accept && (s_op == OP_LOAD);
    assign cmd.run       = accept && (s_op == OP_RUN);
    assign cmd.scan_step = (state_reg == ST_SCAN) && !status.scan_done;
    assign cmd.emit      = (state_reg == ST_EMIT) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.run && !status.count_zero) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = status.left_one ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ hdl/shortest_seek_first_scheduler.sv @@
// ----------------------------------------------------------------------------
// shortest_seek_first_scheduler
// Stores request tracks and, on a run request, serves them nearest first
// from the given head track, one result per stored request.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid / s_ready  in_t  (op, track)
//   m_       out  m_valid / m_ready  out_t (index, tracks, distances, last)
//
// a run with n stored requests does n selections; each selection scans all n
// entries through the single memory read port, then registers the result.
// the next selection scans while a result waits; it stalls only when a new
// result is ready and the previous one is still not taken.
// no input is taken during a run. reset needs no clearing pass.
// ----------------------------------------------------------------------------
module shortest_seek_first_scheduler #(
    parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sstf_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sstf_pkg::out_t m_data
);
    import sstf_pkg::*;

    sstf_cmd_t  cmd;
    sstf_stat_t status;

    sstf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .m_ready (m_ready),
        .status  (status),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    sstf_dp #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_data),
        .status   (status),
        .out_data (m_data)
    );

    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    // every emit follows a scan that found an unserved request
    a_emit_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.best_found)
        else $error("emit without a selected request");

    // after the final result the block takes requests again
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.left_one) |=> (s_ready && status.count_zero))
        else $error("not idle after the last result");

    // scan and emit never overlap a new request
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step || cmd.emit) |-> !s_ready)
        else $error("request accepted during a run");

endmodule
